// ----- design/hst_pkg.sv -----
// Shared types, constants and callsign helpers for the heard station table.
`default_nettype none
package hst_pkg;

  localparam logic [31:0] MAX_AGE_RESET = 32'd3600000;
  localparam logic [7:0]  HYPHEN        = 8'h2D;
  localparam logic [7:0]  LOWER_A       = 8'h61;
  localparam logic [7:0]  LOWER_Z       = 8'h7A;
  localparam logic [7:0]  CASE_BIT      = 8'h20;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LK_RD,
    ST_LK_EV,
    ST_AG_RD,
    ST_AG_EV,
    ST_EV_ORD,
    ST_EV_RD,
    ST_EV_EV,
    ST_CP_RD,
    ST_CP_WR,
    ST_WRITE
  } hst_state_e;

  typedef struct packed {
    logic        clr;
    logic [63:0] callsign;
    logic [31:0] now_ms;
    logic [8:0]  rssi_dbm;
    logic [7:0]  snr_quarter_db;
    logic [3:0]  spreading_factor;
    logic [18:0] bandwidth_hz;
  } hst_req_t;

  typedef struct packed {
    logic [4:0]  slot_index;
    logic        was_new;
    logic [15:0] heard_count;
    logic        digipeater_flag;
    logic [5:0]  aged_out_count;
    logic        evicted_oldest;
    logic [5:0]  station_count;
  } hst_res_t;

  typedef struct packed {
    logic [63:0] callsign;
    logic [31:0] last_heard;
    logic [8:0]  rssi;
    logic [7:0]  snr;
    logic [3:0]  sf;
    logic [18:0] bandwidth;
    logic [15:0] count;
    logic        digi;
  } hst_row_t;

  localparam int unsigned ROW_W = $bits(hst_row_t);

  // Zero every byte from the first zero byte downwards.
  function automatic logic [63:0] hst_truncate(input logic [63:0] c);
    logic [63:0] r;
    logic        live;
    r    = '0;
    live = 1'b1;
    for (int k = 7; k >= 0; k--) begin
      live = live && (c[8*k +: 8] != 8'h00);
      if (live) r[8*k +: 8] = c[8*k +: 8];
    end
    return r;
  endfunction

  // Fold lower-case ASCII letters to upper case.
  function automatic logic [63:0] hst_fold(input logic [63:0] c);
    logic [63:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      if (c[8*k +: 8] >= LOWER_A && c[8*k +: 8] <= LOWER_Z) begin
        r[8*k +: 8] = c[8*k +: 8] - CASE_BIT;
      end
    end
    return r;
  endfunction

  function automatic logic hst_has_hyphen(input logic [63:0] c);
    logic h;
    h = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (c[8*k +: 8] == HYPHEN) h = 1'b1;
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// ----- design/hst_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module hst_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- design/hst_ctrl.sv -----
// Table sequencer: lookup, age sweep, oldest eviction, order compaction, write-back and clear.
`default_nettype none
module hst_ctrl #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire hst_pkg::hst_req_t req_i,
  output logic                   req_ready_o,
  input  wire logic [31:0]       max_age_i,
  input  wire logic              res_ready_i,
  output logic                   res_valid_o,
  output hst_pkg::hst_res_t      res_o
);
  import hst_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_DEPTH - 1);

  hst_state_e state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [AW-1:0] wr_q, wr_d;
  logic [AW-1:0] best_q, best_d;
  logic [AW-1:0] evslot_q, evslot_d;
  logic [31:0]   best_age_q, best_age_d;
  logic          have_q, have_d;
  logic          found_q, found_d;
  logic          free_q, free_d;
  logic          evicted_q, evicted_d;
  logic [CW-1:0] aged_q, aged_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  hst_req_t      req_q, req_d;
  logic [63:0]   key_q, key_d;
  hst_row_t      hit_q, hit_d;

  logic          ent_we;
  logic [AW-1:0] ent_waddr, ent_raddr;
  hst_row_t      ent_wrow, ent_row;
  logic [ROW_W-1:0] ent_rdata;
  logic          ord_we;
  logic [AW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;

  logic [31:0]   age;
  logic          is_last, drop, take;
  logic [AW-1:0] best_n;
  logic [63:0]   trunc_call;

  hst_ram #(.W(ROW_W), .DEPTH(TABLE_DEPTH)) u_ent (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wrow),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // Slots in insertion order, oldest at position zero.
  hst_ram #(.W(AW), .DEPTH(TABLE_DEPTH)) u_ord (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  assign ent_row    = hst_row_t'(ent_rdata);
  assign age        = req_q.now_ms - ent_row.last_heard;
  assign is_last    = (idx_q == LastIdx);
  assign trunc_call = hst_truncate(req_i.callsign);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      wr_q      <= '0;
      have_q    <= 1'b0;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
      evicted_q <= 1'b0;
      aged_q    <= '0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      wr_q      <= wr_d;
      have_q    <= have_d;
      found_q   <= found_d;
      free_q    <= free_d;
      evicted_q <= evicted_d;
      aged_q    <= aged_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    best_q     <= best_d;
    evslot_q   <= evslot_d;
    best_age_q <= best_age_d;
    req_q      <= req_d;
    key_q      <= key_d;
    hit_q      <= hit_d;
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    slot_d     = slot_q;
    wr_d       = wr_q;
    best_d     = best_q;
    evslot_d   = evslot_q;
    best_age_d = best_age_q;
    have_d     = have_q;
    found_d    = found_q;
    free_d     = free_q;
    evicted_d  = evicted_q;
    aged_d     = aged_q;
    cnt_d      = cnt_q;
    valid_d    = valid_q;
    req_d      = req_q;
    key_d      = key_q;
    hit_d      = hit_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    ent_we    = 1'b0;
    ent_waddr = slot_q;
    ent_wrow  = hit_q;
    ent_raddr = idx_q;
    ord_we    = 1'b0;
    ord_waddr = wr_q;
    ord_wdata = ord_rdata;
    ord_raddr = idx_q;
    drop      = 1'b0;
    take      = 1'b0;
    best_n    = best_q;

    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d          = req_i;
          req_d.callsign = trunc_call;
          key_d          = hst_fold(trunc_call);
          idx_d          = '0;
          found_d        = 1'b0;
          free_d         = 1'b0;
          aged_d         = '0;
          evicted_d      = 1'b0;
          state_d        = req_i.clr ? ST_WRITE : ST_LK_RD;
        end
      end
      ST_LK_RD: state_d = ST_LK_EV;
      ST_LK_EV: begin
        if (valid_q[idx_q] && hst_fold(ent_row.callsign) == key_q) begin
          found_d = 1'b1;
          slot_d  = idx_q;
          hit_d   = ent_row;
          state_d = ST_WRITE;
        end else begin
          // remember the lowest free slot on the way
          if (!free_q && !valid_q[idx_q]) begin
            free_d = 1'b1;
            slot_d = idx_q;
          end
          if (is_last) begin
            idx_d   = '0;
            state_d = (free_q || !valid_q[idx_q]) ? ST_WRITE : ST_AG_RD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_LK_RD;
          end
        end
      end
      ST_AG_RD: state_d = ST_AG_EV;
      ST_AG_EV: begin
        drop = valid_q[idx_q] && (age > max_age_i);
        if (drop) begin
          valid_d[idx_q] = 1'b0;
          aged_d         = aged_q + 1'b1;
          cnt_d          = cnt_q - 1'b1;
          if (!free_q) begin
            free_d = 1'b1;
            slot_d = idx_q;
          end
        end
        if (is_last) begin
          idx_d   = '0;
          wr_d    = '0;
          have_d  = 1'b0;
          state_d = (drop || aged_q != '0) ? ST_CP_RD : ST_EV_ORD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_AG_RD;
        end
      end
      ST_EV_ORD: state_d = ST_EV_RD;
      ST_EV_RD: begin
        ent_raddr = ord_rdata;
        evslot_d  = ord_rdata;
        state_d   = ST_EV_EV;
      end
      ST_EV_EV: begin
        // scan in insertion order: strictly older wins, ties keep the earlier
        take = valid_q[evslot_q] && (!have_q || age > best_age_q);
        if (take) begin
          best_n     = evslot_q;
          best_d     = evslot_q;
          best_age_d = age;
          have_d     = 1'b1;
        end
        if (is_last) begin
          if (have_q || take) begin
            valid_d[best_n] = 1'b0;
            cnt_d           = cnt_q - 1'b1;
            evicted_d       = 1'b1;
            free_d          = 1'b1;
            slot_d          = best_n;
          end
          idx_d   = '0;
          wr_d    = '0;
          state_d = ST_CP_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_EV_ORD;
        end
      end
      ST_CP_RD: state_d = ST_CP_WR;
      ST_CP_WR: begin
        // close the gaps left by dropped slots
        if (valid_q[ord_rdata]) begin
          ord_we    = 1'b1;
          ord_waddr = wr_q;
          ord_wdata = ord_rdata;
          wr_d      = wr_q + 1'b1;
        end
        if (is_last) begin
          state_d = ST_WRITE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_CP_RD;
        end
      end
      ST_WRITE: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
          if (req_q.clr) begin
            valid_d = '0;
            cnt_d   = '0;
          end else begin
            ent_we              = 1'b1;
            ent_waddr           = slot_q;
            ent_wrow.last_heard = req_q.now_ms;
            ent_wrow.rssi       = req_q.rssi_dbm;
            ent_wrow.snr        = req_q.snr_quarter_db;
            ent_wrow.sf         = req_q.spreading_factor;
            ent_wrow.bandwidth  = req_q.bandwidth_hz;
            if (found_q) begin
              ent_wrow.callsign = hit_q.callsign;
              ent_wrow.digi     = hit_q.digi;
              ent_wrow.count    = (hit_q.count == 16'hFFFF) ? hit_q.count
                                                            : hit_q.count + 16'd1;
            end else begin
              ent_wrow.callsign = req_q.callsign;
              ent_wrow.digi     = !hst_has_hyphen(req_q.callsign);
              ent_wrow.count    = 16'd1;
              valid_d[slot_q]   = 1'b1;
              cnt_d             = cnt_q + 1'b1;
              ord_we            = 1'b1;
              ord_waddr         = AW'(cnt_q);
              ord_wdata         = slot_q;
            end
            res_o.slot_index      = 5'(slot_q);
            res_o.was_new         = !found_q;
            res_o.heard_count     = ent_wrow.count;
            res_o.digipeater_flag = ent_wrow.digi;
            res_o.aged_out_count  = 6'(aged_q);
            res_o.evicted_oldest  = evicted_q;
            res_o.station_count   = 6'(cnt_d);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/heard_station_table_top.sv -----
// Heard station table: stream request and result channels plus an APB register port.
//
// Input transfers carry one request: tuser selects a heard packet (0) or a table
// clear (1); tdata carries the callsign, time and link figures. Each request
// yields exactly one result transfer on the master side.
// A heard packet walks the entry RAM slot by slot, reading and then comparing
// each slot, looking for its callsign; an update stops at the match, while an
// insert into a table with space scans every slot. An insert into a full table
// adds an age sweep, an oldest search in insertion order when nothing aged out
// and a compaction of the order RAM. A clear goes straight to its write-back.
// The RAMs give one read per cycle; one request is worked at a time and the
// next is taken in the cycle after the result.
// The result sits in an output register; the next request is taken while it
// waits, and the sequencer holds its final write-back until that register frees.
// Reset empties the table (valid bits and count) and sets max_age_ms to 3600000;
// the RAM contents need no clearing. max_age_ms lies at byte address 0.
`default_nettype none
module heard_station_table_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // callsign[63:0], now_ms[95:64], rssi_dbm[104:96], snr_quarter_db[112:105],
  // spreading_factor[116:113], bandwidth_hz[135:117]
  input  wire logic [135:0] s_axis_tdata_i,
  // req_type[0]
  input  wire logic         s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // slot_index[4:0], was_new[5], heard_count[21:6], digipeater_flag[22],
  // aged_out_count[28:23], evicted_oldest[29], station_count[35:30], zero[39:36]
  output logic [39:0]       m_axis_tdata_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import hst_pkg::*;

  logic [31:0] max_age_q;
  logic        out_valid_q;
  hst_res_t    out_q;
  hst_req_t    req;
  hst_res_t    res;
  logic        res_valid, res_ready, req_ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? max_age_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= MAX_AGE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      max_age_q <= pwdata;
    end
  end

  assign req.clr              = s_axis_tuser_i;
  assign req.callsign         = s_axis_tdata_i[63:0];
  assign req.now_ms           = s_axis_tdata_i[95:64];
  assign req.rssi_dbm         = s_axis_tdata_i[104:96];
  assign req.snr_quarter_db   = s_axis_tdata_i[112:105];
  assign req.spreading_factor = s_axis_tdata_i[116:113];
  assign req.bandwidth_hz     = s_axis_tdata_i[135:117];

  assign s_axis_tready_o = req_ready;
  assign res_ready       = !out_valid_q || m_axis_tready_i;

  hst_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_i       (req),
    .req_ready_o (req_ready),
    .max_age_i   (max_age_q),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_q.station_count, out_q.evicted_oldest,
                            out_q.aged_out_count, out_q.digipeater_flag,
                            out_q.heard_count, out_q.was_new, out_q.slot_index};

endmodule
`default_nettype wire

// ----- tb/heard_station_table_top_tb.sv -----
// Self-checking testbench for the heard station table: stream requests, APB register.
`timescale 1ns / 1ps
module heard_station_table_top_tb;

  localparam int unsigned DEPTH     = 32;
  localparam int unsigned POOL_SIZE = 48;
  localparam logic [2:0]  ADDR_MAX_AGE = 3'd0;
  localparam bit          REQ_HEARD = 1'b0;
  localparam bit          REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic [4:0]  slot_index;
    logic        was_new;
    logic [15:0] heard_count;
    logic        digipeater_flag;
    logic [5:0]  aged_out_count;
    logic        evicted_oldest;
    logic [5:0]  station_count;
  } station_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [135:0] s_axis_tdata_i;
  logic         s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [39:0]  m_axis_tdata_o;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  heard_station_table_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Mirror of the table
  logic [31:0] age_limit;
  bit          row_valid [DEPTH];
  logic [63:0] row_call  [DEPTH];
  logic [31:0] row_heard [DEPTH];
  logic [15:0] row_count [DEPTH];
  logic        row_digi  [DEPTH];
  int unsigned row_rank  [DEPTH];

  station_result_t pending_results[$];
  int unsigned     mismatches;

  logic [63:0] call_pool [POOL_SIZE];
  logic [31:0] clock_ms;
  int unsigned burst_left;
  bit          steady_send;
  int unsigned hold_cycles;
  bit          fast_rx;

  function automatic logic [63:0] strip_call(logic [63:0] c);
    logic [63:0] r;
    bit          live;
    r    = '0;
    live = 1'b1;
    for (int k = 7; k >= 0; k--) begin
      if (c[8*k +: 8] == 8'h00) live = 1'b0;
      if (live) r[8*k +: 8] = c[8*k +: 8];
    end
    return r;
  endfunction

  function automatic logic [63:0] upper_call(logic [63:0] c);
    logic [63:0] r;
    r = c;
    for (int k = 0; k < 8; k++)
      if (c[8*k +: 8] inside {[8'h61:8'h7A]}) r[8*k +: 8] = c[8*k +: 8] - 8'h20;
    return r;
  endfunction

  function automatic int unsigned live_rows();
    int unsigned n;
    n = 0;
    for (int i = 0; i < DEPTH; i++) if (row_valid[i]) n++;
    return n;
  endfunction

  function automatic void remove_row(int unsigned idx);
    row_valid[idx] = 1'b0;
    for (int j = 0; j < DEPTH; j++)
      if (row_valid[j] && row_rank[j] > row_rank[idx]) row_rank[j]--;
  endfunction

  // Work out the result of one accepted request and update the mirror.
  function automatic void predict_request(bit clr, logic [63:0] raw_call, logic [31:0] now);
    station_result_t res;
    logic [63:0]     call;
    logic [63:0]     key;
    int unsigned     slot;
    int unsigned     best;
    int unsigned     aged;
    bit              found;
    bit              evicted;
    bit              have;
    logic [31:0]     age_a;
    logic [31:0]     age_b;
    res     = '0;
    call    = strip_call(raw_call);
    key     = upper_call(call);
    slot    = 0;
    best    = 0;
    aged    = 0;
    found   = 1'b0;
    evicted = 1'b0;
    have    = 1'b0;
    if (clr) begin
      for (int i = 0; i < DEPTH; i++) row_valid[i] = 1'b0;
      pending_results = {pending_results, res};
      return;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (!found && row_valid[i] && upper_call(row_call[i]) == key) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      if (live_rows() >= DEPTH) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (row_valid[i] && (now - row_heard[i]) > age_limit) begin
            remove_row(i);
            aged++;
          end
        end
        if (live_rows() >= DEPTH) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (row_valid[i]) begin
              if (!have) begin
                best = i;
                have = 1'b1;
              end else begin
                age_a = now - row_heard[i];
                age_b = now - row_heard[best];
                if (age_a > age_b || (age_a == age_b && row_rank[i] < row_rank[best]))
                  best = i;
              end
            end
          end
          if (have) begin
            remove_row(best);
            evicted = 1'b1;
          end
        end
      end
      have = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        if (!have && !row_valid[i]) begin
          slot = i;
          have = 1'b1;
        end
      end
      row_rank[slot]  = live_rows();
      row_valid[slot] = 1'b1;
      row_call[slot]  = call;
      row_count[slot] = '0;
      row_digi[slot]  = 1'b1;
      for (int k = 0; k < 8; k++)
        if (call[8*k +: 8] == hst_pkg::HYPHEN) row_digi[slot] = 1'b0;
    end
    row_heard[slot] = now;
    if (row_count[slot] != 16'hFFFF) row_count[slot]++;
    res.slot_index      = slot[4:0];
    res.was_new         = !found;
    res.heard_count     = row_count[slot];
    res.digipeater_flag = row_digi[slot];
    res.aged_out_count  = aged[5:0];
    res.evicted_oldest  = evicted;
    res.station_count   = 6'(live_rows());
    pending_results = {pending_results, res};
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    station_result_t got;
    station_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.slot_index      = m_axis_tdata_o[4:0];
      got.was_new         = m_axis_tdata_o[5];
      got.heard_count     = m_axis_tdata_o[21:6];
      got.digipeater_flag = m_axis_tdata_o[22];
      got.aged_out_count  = m_axis_tdata_o[28:23];
      got.evicted_oldest  = m_axis_tdata_o[29];
      got.station_count   = m_axis_tdata_o[35:30];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", m_axis_tdata_o);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_axis_tdata_o[39:36] !== 4'h0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch (expected/actual): slot %0d/%0d new %0d/%0d count %0d/%0d",
                     want.slot_index, got.slot_index, want.was_new, got.was_new,
                     want.heard_count, got.heard_count);
            $display("  digi %0d/%0d aged %0d/%0d evict %0d/%0d stations %0d/%0d pad %h",
                     want.digipeater_flag, got.digipeater_flag, want.aged_out_count,
                     got.aged_out_count, want.evicted_oldest, got.evicted_oldest,
                     want.station_count, got.station_count, m_axis_tdata_o[39:36]);
          end
        end
      end
    end
  end

  // Receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    mode      = 0;
    mode_left = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_cycles > 0) begin
        m_axis_tready_i = 1'b0;
        hold_cycles--;
      end else if (fast_rx) begin
        m_axis_tready_i = 1'b1;
      end else begin
        case (mode)
          0:       m_axis_tready_i = 1'b1;
          1:       m_axis_tready_i = ($urandom_range(0, 3) != 0);
          2:       m_axis_tready_i = ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i = 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  task automatic send_item(bit clr, logic [63:0] call, logic [31:0] now, logic [8:0] rssi,
                           logic [7:0] snr, logic [3:0] sf, logic [18:0] bw);
    int unsigned gap;
    @(negedge clk_i);
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 8);
        s_axis_tvalid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left--;
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = clr;
    s_axis_tdata_i  = {bw, sf, snr, rssi, now, call};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_request(clr, call, now);
  endtask

  task automatic sender_idle();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic heard(logic [63:0] call, logic [31:0] now);
    logic [8:0] rssi;
    rssi = 9'($urandom_range(0, 250) - 200);
    send_item(REQ_HEARD, call, now, rssi, 8'($urandom), 4'($urandom_range(5, 12)),
              19'($urandom_range(0, 500000)));
  endtask

  task automatic drain();
    sender_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write max_age_ms while idle, then read it back.
  task automatic set_age_limit(logic [31:0] value);
    drain();
    repeat (4) @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = ADDR_MAX_AGE; pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    age_limit = value;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    check_age_limit();
  endtask

  task automatic check_age_limit();
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b0; paddr = ADDR_MAX_AGE;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== age_limit) begin
      mismatches++;
      if (mismatches <= 10) $display("max_age_ms read: expected %h actual %h", age_limit, prdata);
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  function automatic logic [63:0] make_callsign();
    logic [63:0] c;
    int unsigned len;
    int unsigned pick;
    c   = '0;
    len = $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 40);
      if (pick < 26)      c[8*(7-k) +: 8] = 8'(8'h41 + pick);
      else if (pick < 36) c[8*(7-k) +: 8] = 8'(8'h30 + pick - 26);
      else if (k > 0)     c[8*(7-k) +: 8] = hst_pkg::HYPHEN;
      else                c[8*(7-k) +: 8] = 8'h4B;
    end
    return c;
  endfunction

  // Same key in another spelling: flip letter case, fill bytes past the terminator.
  function automatic logic [63:0] respell(logic [63:0] c);
    logic [63:0] r;
    logic [63:0] u;
    bit          ended;
    r     = c;
    u     = upper_call(c);
    ended = 1'b0;
    for (int k = 7; k >= 0; k--) begin
      if (ended) begin
        if ($urandom_range(0, 1)) r[8*k +: 8] = 8'($urandom);
      end else if (c[8*k +: 8] == 8'h00) begin
        ended = 1'b1;
      end else if (u[8*k +: 8] inside {[8'h41:8'h5A]} && $urandom_range(0, 1)) begin
        r[8*k +: 8] = c[8*k +: 8] ^ 8'h20;
      end
    end
    return r;
  endfunction

  task automatic advance_clock();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15)      clock_ms = clock_ms;
    else if (pick < 95) clock_ms = clock_ms + $urandom_range(1, 3000);
    else                clock_ms = $urandom;
  endtask

  task automatic test_register_reset();
    age_limit = hst_pkg::MAX_AGE_RESET;
    check_age_limit();
  endtask

  task automatic test_directed();
    logic [63:0] call_a;
    call_a = {"N0CALL", 16'h0000};
    steady_send = 1'b1;
    send_item(REQ_CLEAR, '1, '1, '1, '1, '1, '1);
    send_item(REQ_HEARD, call_a, 32'hFFFF_FFFF, 9'h038, 8'h80, 4'd5, 19'd0);
    send_item(REQ_HEARD, {"n0call", 8'h00, 8'hA5}, 32'd0, 9'h032, 8'h7F, 4'd12, 19'd500000);
    send_item(REQ_HEARD, {"N0CALL", 8'h00, 8'hFF}, 32'd5, 9'h1FF, 8'h00, 4'd8, 19'd125000);
    send_item(REQ_HEARD, 64'h0, 32'd7, 9'h000, 8'hFF, 4'd7, 19'd250000);
    send_item(REQ_HEARD, {8'h00, 56'hFF_FFFF_FFFF_FFFF}, 32'd8, 9'h100, 8'h01, 4'd9, 19'd62500);
    send_item(REQ_HEARD, {"AB-1", 32'h0}, 32'd9, 9'h0AA, 8'h55, 4'd10, 19'h2AAAA);
    send_item(REQ_HEARD, {"ab-1", 32'hDEAD_BEEF}, 32'd9, 9'h155, 8'hAA, 4'd11, 19'h55555);
    send_item(REQ_HEARD, "WXYZ-123", 32'h8000_0000, 9'h1C0, 8'h7F, 4'd6, 19'd41700);
    send_item(REQ_HEARD, "wxyz-123", 32'h8000_0001, 9'h1C0, 8'h7F, 4'd6, 19'd41700);
    send_item(REQ_HEARD, "[`{@az~]", 32'd11, 9'h01, 8'h02, 4'd5, 19'd7800);
    send_item(REQ_HEARD, "{@AZ~]`[", 32'd12, 9'h01, 8'h02, 4'd5, 19'd7800);
    send_item(REQ_HEARD, '1, 32'd13, 9'h1FF, 8'hFF, 4'd12, 19'd500000);
    send_item(REQ_CLEAR, '0, '0, '0, '0, '0, '0);
    send_item(REQ_HEARD, call_a, 32'd20, 9'h038, 8'h80, 4'd5, 19'd0);
    steady_send = 1'b0;
    drain();
  endtask

  // Drive one station many times in a row.
  task automatic test_repeat_station();
    steady_send = 1'b1;
    fast_rx     = 1'b1;
    send_item(REQ_CLEAR, '0, '0, '0, '0, '0, '0);
    for (int i = 0; i < 60; i++) heard({"SAT", 40'h0}, i);
    steady_send = 1'b0;
    fast_rx     = 1'b0;
    drain();
  endtask

  task automatic test_full_table();
    set_age_limit(32'hFFFF_FFFF);
    send_item(REQ_CLEAR, '0, '0, '0, '0, '0, '0);
    // equal times: eviction falls back on insertion order
    for (int i = 0; i < 40; i++) heard(call_pool[i], 32'd1000);
    set_age_limit(32'd0);
    for (int i = 0; i < 40; i++) heard(call_pool[(i * 7) % POOL_SIZE], 32'd1000 + i / 4);
    set_age_limit(32'd5000);
    for (int i = 0; i < 40; i++) heard(call_pool[POOL_SIZE - 1 - i], 32'hFFFF_F000 + i * 500);
    drain();
  endtask

  task automatic random_phase(int unsigned count, bit with_hold_off);
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      if (with_hold_off && i == count / 2) hold_cycles = 600;
      advance_clock();
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_item(REQ_CLEAR, {$urandom, $urandom}, $urandom, 9'($urandom), 8'($urandom),
                  4'($urandom), 19'($urandom));
      end else if (pick < 12) begin
        heard({$urandom, $urandom}, clock_ms);
      end else begin
        heard(respell(call_pool[$urandom_range(0, POOL_SIZE - 1)]), clock_ms);
      end
    end
    drain();
  endtask

  task automatic test_random();
    set_age_limit(32'd20000);
    random_phase(400, 1'b1);
    set_age_limit(32'd0);
    random_phase(250, 1'b0);
    set_age_limit(32'hFFFF_FFFF);
    random_phase(250, 1'b0);
    set_age_limit($urandom_range(1000, 60000));
    random_phase(300, 1'b0);
    set_age_limit(hst_pkg::MAX_AGE_RESET);
    random_phase(250, 1'b0);
  endtask

  initial begin
    #600_000_000;
    $display("heard_station_table_top regression: fail");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tdata_i  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    mismatches  = 0;
    burst_left  = 0;
    steady_send = 1'b0;
    hold_cycles = 0;
    fast_rx     = 1'b0;
    clock_ms    = 32'd100;
    age_limit   = hst_pkg::MAX_AGE_RESET;
    for (int i = 0; i < DEPTH; i++) row_valid[i] = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) call_pool[i] = make_callsign();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_reset();
    test_directed();
    test_full_table();
    test_random();
    test_repeat_station();

    repeat (400) @(posedge clk_i);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("heard_station_table_top regression: pass");
    end else begin
      $display("heard_station_table_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- heard_station_table_top.f -----
design/hst_pkg.sv
design/hst_ram.sv
design/hst_ctrl.sv
design/heard_station_table_top.sv
tb/heard_station_table_top_tb.sv
